>>> rtl/ffa_pkg.sv
// shared types and constants of the first-fit frame allocator
// no dependencies; imported by ffa_div and first_fit_frame_allocator
package ffa_pkg;

    localparam int NUM_FRAMES  = 64;
    localparam int OWNER_BITS  = 8;
    localparam int IDX_W       = $clog2(NUM_FRAMES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIV_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // function codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_ALLOC = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_FREED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

    localparam logic [15:0] FRAME_SIZE_RST    = 16'd256;
    localparam logic [6:0]  FRAMES_IN_USE_RST = 7'd64;

    typedef struct packed {
        logic        func;
        logic [7:0]  owner_id;
        logic [15:0] request_bytes;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] first_frame;
        logic [6:0] frames_changed;
    } rsp_t;

endpackage

>>> rtl/ffa_div.sv
// restoring divider, one quotient bit per cycle
// depends on ffa_pkg
module ffa_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ffa_pkg::DIV_W-1:0] dividend,
    input  logic [ffa_pkg::DIV_W-1:0] divisor,
    output logic                      done,
    output logic [ffa_pkg::DIV_W-1:0] quotient
);
    import ffa_pkg::*;

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            // a zero frame size divides as one
            dvs_next  = (divisor == '0) ? DIV_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/first_fit_frame_allocator.sv
// first-fit contiguous frame allocator: occupancy flags, owner tag memory, sequencer
// free scans the managed frames; allocate runs the divider, then scans for a free run,
// tags each frame of the run and registers the result
// one transaction at a time; req_stall is high after an accept until the result is registered
// reset: occupancy flags cleared at once, config regs to frame size 256 and 64 frames
module first_fit_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ffa_pkg::req_t                 req,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output ffa_pkg::rsp_t                 rsp,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ffa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_ASSIGN,
        ST_FREE,
        ST_RESULT
    } state_t;

    // control and config
    state_t                state_reg, state_next;
    logic [15:0]           frame_size_reg, frame_size_next;
    logic [6:0]            frames_in_use_reg, frames_in_use_next;
    logic [NUM_FRAMES-1:0] occ_reg, occ_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  cmp_valid_reg, cmp_valid_next;

    // per-transaction working registers
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]      run_reg, run_next;
    logic [IDX_W-1:0]      asg_idx_reg, asg_idx_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [1:0]            status_reg, status_next;
    logic [IDX_W-1:0]      first_reg, first_next;
    logic [CNT_W-1:0]      changed_reg, changed_next;
    rsp_t                  rsp_reg, rsp_next;

    // owner tag memory
    logic [OWNER_BITS-1:0] owner_mem [NUM_FRAMES];
    logic [OWNER_BITS-1:0] owner_rd_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;

    // divider
    logic                  div_start;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;

    logic                  req_accept;
    logic [CNT_W-1:0]      n_frames;
    logic                  scan_occ;
    logic [CNT_W-1:0]      run_inc;

    assign req_accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // managed frames, saturated to the size of the bank
    assign n_frames = (frames_in_use_reg > CNT_W'(NUM_FRAMES)) ?
                      CNT_W'(NUM_FRAMES) : frames_in_use_reg;

    assign scan_occ = occ_reg[scan_idx_reg[IDX_W-1:0]];
    assign run_inc  = run_reg + 1'b1;

    ffa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.request_bytes),
        .divisor  (frame_size_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next         = state_reg;
        frame_size_next    = frame_size_reg;
        frames_in_use_next = frames_in_use_reg;
        occ_next           = occ_reg;
        rsp_valid_next     = rsp_valid_reg;
        cmp_valid_next     = 1'b0;
        owner_next         = owner_reg;
        count_next         = count_reg;
        scan_idx_next      = scan_idx_reg;
        run_next           = run_reg;
        asg_idx_next       = asg_idx_reg;
        left_next          = left_reg;
        cmp_idx_next       = cmp_idx_reg;
        status_next        = status_reg;
        first_next         = first_reg;
        changed_next       = changed_reg;
        rsp_next           = rsp_reg;
        div_start          = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = asg_idx_reg;
        mem_raddr          = scan_idx_reg[IDX_W-1:0];

        // config writes, only while idle by contract
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_SIZE:    frame_size_next    = cfg_data;
                CFG_FRAMES_IN_USE: frames_in_use_next = cfg_data[6:0];
                default:           ;
            endcase
        end

        // result register drains on its own
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    owner_next    = req.owner_id[OWNER_BITS-1:0];
                    first_next    = '0;
                    changed_next  = '0;
                    scan_idx_next = '0;
                    run_next      = '0;
                    if (req.func == FUNC_FREE)
                        state_next = ST_FREE;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    count_next = div_quo[CNT_W-1:0];
                    if (div_quo == '0)
                    begin
                        // zero frames: success with nothing assigned
                        status_next = STATUS_ALLOC;
                        state_next  = ST_RESULT;
                    end
                    else if (div_quo > DIV_W'(n_frames))
                    begin
                        status_next = STATUS_NOFIT;
                        state_next  = ST_RESULT;
                    end
                    else
                        state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // one frame per cycle, track length of the current free run
                if (scan_idx_reg == n_frames)
                begin
                    status_next = STATUS_NOFIT;
                    first_next  = '0;
                    state_next  = ST_RESULT;
                end
                else if (scan_occ)
                begin
                    run_next      = '0;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else if (run_inc == count_reg)
                begin
                    asg_idx_next = IDX_W'(scan_idx_reg - count_reg + 1'b1);
                    first_next   = IDX_W'(scan_idx_reg - count_reg + 1'b1);
                    left_next    = count_reg;
                    state_next   = ST_ASSIGN;
                end
                else
                begin
                    run_next      = run_inc;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            ST_ASSIGN:
            begin
                // tag one frame of the run per cycle
                mem_we                = 1'b1;
                occ_next[asg_idx_reg] = 1'b1;
                asg_idx_next          = asg_idx_reg + 1'b1;
                left_next             = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    status_next  = STATUS_ALLOC;
                    changed_next = count_reg;
                    state_next   = ST_RESULT;
                end
            end

            ST_FREE:
            begin
                // read tag of scan_idx, compare tag of the previous frame
                if (scan_idx_reg != n_frames)
                begin
                    scan_idx_next  = scan_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg && occ_reg[cmp_idx_reg] && (owner_rd_reg == owner_reg))
                begin
                    occ_next[cmp_idx_reg] = 1'b0;
                    changed_next          = changed_reg + 1'b1;
                end
                if (scan_idx_reg == n_frames && !cmp_valid_reg)
                begin
                    status_next = STATUS_FREED;
                    state_next  = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status         = status_reg;
                    rsp_next.first_frame    = first_reg;
                    rsp_next.frames_changed = changed_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            frame_size_reg    <= FRAME_SIZE_RST;
            frames_in_use_reg <= FRAMES_IN_USE_RST;
            occ_reg           <= '0;
            rsp_valid_reg     <= 1'b0;
            cmp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            frame_size_reg    <= frame_size_next;
            frames_in_use_reg <= frames_in_use_next;
            occ_reg           <= occ_next;
            rsp_valid_reg     <= rsp_valid_next;
            cmp_valid_reg     <= cmp_valid_next;
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge clk)
    begin
        owner_reg    <= owner_next;
        count_reg    <= count_next;
        scan_idx_reg <= scan_idx_next;
        run_reg      <= run_next;
        asg_idx_reg  <= asg_idx_next;
        left_reg     <= left_next;
        cmp_idx_reg  <= cmp_idx_next;
        status_reg   <= status_next;
        first_reg    <= first_next;
        changed_reg  <= changed_next;
        rsp_reg      <= rsp_next;
    end

    // owner tag memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            owner_mem[mem_waddr] <= owner_reg;
        owner_rd_reg <= owner_mem[mem_raddr];
    end

    // a request accepted puts the sequencer to work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> state_reg != ST_IDLE)
        else $error("sequencer idle after accepted request");

    // only free frames are ever tagged by an allocation
    a_assign_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ASSIGN |-> !occ_reg[asg_idx_reg])
        else $error("allocation overwrote an occupied frame");

    // failed or free results carry no first frame
    a_rsp_first: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STATUS_NOFIT || rsp.status == STATUS_FREED)
        |-> rsp.first_frame == '0)
        else $error("first frame set on a non-allocating result");

    // a failed allocation changes no frame
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_NOFIT |-> rsp.frames_changed == '0)
        else $error("frames changed on a failed allocation");

endmodule
